/* design/generational_handle_allocator_unit_macros.svh */
// Assertion macros shared by the handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GHAU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GHAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* design/ghau_pkg.sv */
// Package with the types, constants and helpers of the handle allocator.
`default_nettype none

package ghau_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int GEN_PORT_W = 16;
  localparam int ACT_W      = 3;
  localparam int OUT_DEPTH  = 3;
  localparam int OCC_W      = $clog2(OUT_DEPTH + 1);
  localparam int PTR_W      = $clog2(OUT_DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE       = ACT_W'(0),
    ACT_DESTROY      = ACT_W'(1),
    ACT_CHECK        = ACT_W'(2),
    ACT_SET_ACTIVE   = ACT_W'(3),
    ACT_QUERY_ACTIVE = ACT_W'(4)
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One entry of the slot table.
  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic                active;
  } slot_ent_t;

  localparam int SLOT_W = $bits(slot_ent_t);

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] slot;
  } stack_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] top_nxt;
    logic [CNT_W-1:0] depth;
  } stack_stat_t;

  typedef struct packed {
    status_t               status;
    logic [IDX_W-1:0]      index;
    logic [GEN_PORT_W-1:0] gen;
    logic                  active;
    logic [CNT_W-1:0]      live;
  } result_t;

  // A presented generation matches only if all its bits agree with the stored one.
  function automatic logic gen_match(input logic [GEN_BITS-1:0] stored,
                                     input logic [GEN_PORT_W-1:0] presented);
    logic [63:0] s_ext;
    logic [63:0] p_ext;
    s_ext = 64'(stored);
    p_ext = 64'(presented);
    return s_ext == p_ext;
  endfunction

  function automatic logic [GEN_PORT_W-1:0] gen_to_port(input logic [GEN_BITS-1:0] stored);
    logic [63:0] s_ext;
    s_ext = 64'(stored);
    return s_ext[GEN_PORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/ghau_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ghau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/ghau_out_fifo.sv */
// Small result queue between the compute stage and the result channel.
`default_nettype none

module ghau_out_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ghau_pkg::result_t     push_data,
  input  wire logic                  pop_ready,
  output logic                       pop_valid,
  output ghau_pkg::result_t          pop_data,
  output logic [ghau_pkg::OCC_W-1:0] count
);

  ghau_pkg::result_t                 mem_r [ghau_pkg::OUT_DEPTH];
  logic [ghau_pkg::PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [ghau_pkg::PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [ghau_pkg::OCC_W-1:0]        count_r, count_nxt;
  logic                              pop;

  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ghau_pkg::PTR_W'(ghau_pkg::OUT_DEPTH - 1)) ?
                   '0 : wr_ptr_r + ghau_pkg::PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ghau_pkg::PTR_W'(ghau_pkg::OUT_DEPTH - 1)) ?
                   '0 : rd_ptr_r + ghau_pkg::PTR_W'(1);
    end
    count_nxt = count_r + ghau_pkg::OCC_W'(push) - ghau_pkg::OCC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/ghau_free_stack.sv */
// LIFO of recycled slots: top entry in a register, the rest in a RAM with prefetch.
`default_nettype none

`include "generational_handle_allocator_unit_macros.svh"

module ghau_free_stack (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ghau_pkg::stack_op_t  op,
  output ghau_pkg::stack_stat_t     stat
);

  logic [ghau_pkg::CNT_W-1:0] depth_r, depth_nxt;
  logic [ghau_pkg::IDX_W-1:0] top_r, top_nxt;
  logic                       fwd_r, fwd_nxt;
  logic [ghau_pkg::IDX_W-1:0] fwd_data_r;
  logic [ghau_pkg::IDX_W-1:0] ram_q;
  logic [ghau_pkg::IDX_W-1:0] below;
  logic                       we;
  logic [ghau_pkg::IDX_W-1:0] waddr;
  logic [ghau_pkg::IDX_W-1:0] raddr;

  // The RAM holds every entry below the top. The entry just below the top is
  // read every cycle for the state that the current cycle leaves behind, so a
  // pop always finds its new top in the read register or the forwarding register.
  always_comb begin
    below     = fwd_r ? fwd_data_r : ram_q;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    we        = 1'b0;
    waddr     = ghau_pkg::IDX_W'(depth_r - ghau_pkg::CNT_W'(1));
    priority if (op.push) begin
      we        = (depth_r != '0);
      top_nxt   = op.slot;
      depth_nxt = depth_r + ghau_pkg::CNT_W'(1);
    end else if (op.pop) begin
      top_nxt   = below;
      depth_nxt = depth_r - ghau_pkg::CNT_W'(1);
    end
    raddr   = ghau_pkg::IDX_W'(depth_nxt - ghau_pkg::CNT_W'(2));
    fwd_nxt = we && (waddr == raddr);
  end

  ghau_ram #(
    .WIDTH (ghau_pkg::IDX_W),
    .DEPTH (ghau_pkg::MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      fwd_r   <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  assign stat = '{top: top_r, top_nxt: top_nxt, depth: depth_r};

  `GHAU_ASSERT_NEXT(a_push_lands_on_top, op.push, top_r == $past(op.slot))
  `GHAU_ASSERT_NOW(a_pop_not_empty, op.pop, depth_r != '0)
  `GHAU_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= ghau_pkg::CNT_W'(ghau_pkg::MAX_SLOTS))

endmodule

`default_nettype wire

/* design/generational_handle_allocator_unit.sv */
// Top level of the generational handle allocator.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    action, slot_index, slot_generation, active_value
//   out_     output     out_valid/out_ready  status, handle_index, handle_generation,
//                                            active_flag, live_count
//
// A transaction accepted on the input reaches the compute stage in the next cycle,
// where the slot table read data (issued from the input port at accept time) is
// ready. All state updates and the result are produced in that single cycle, so
// one transaction per cycle is sustained while the result queue has room; out_valid
// rises once the result from the compute stage is in the queue. The rate is set by the
// single slot-table RAM read/write pair per transaction; back-to-back accesses to
// the same slot are covered by forwarding. Results wait in a three-entry queue;
// in_ready drops only when that queue and the compute stage together are full.
// Reset is synchronous, active low, clears all counters and needs no clearing
// pass: table entries are only read after they have been written.
`default_nettype none

`include "generational_handle_allocator_unit_macros.svh"

module generational_handle_allocator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ghau_pkg::ACT_W-1:0]      in_action,
  input  wire logic [ghau_pkg::IDX_W-1:0]      in_slot_index,
  input  wire logic [ghau_pkg::GEN_PORT_W-1:0] in_slot_generation,
  input  wire logic                            in_active_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic [ghau_pkg::IDX_W-1:0]           out_handle_index,
  output logic [ghau_pkg::GEN_PORT_W-1:0]      out_handle_generation,
  output logic                                 out_active_flag,
  output logic [ghau_pkg::CNT_W-1:0]           out_live_count
);

  // Compute stage input register.
  logic                            s1_valid_r;
  logic [ghau_pkg::ACT_W-1:0]      s1_action_r;
  logic [ghau_pkg::IDX_W-1:0]      s1_idx_r;
  logic [ghau_pkg::GEN_PORT_W-1:0] s1_gen_r;
  logic                            s1_actv_r;

  // Allocation counters.
  logic [ghau_pkg::CNT_W-1:0] fresh_r, fresh_nxt;
  logic [ghau_pkg::CNT_W-1:0] live_r, live_nxt;

  // Slot table access and forwarding.
  logic                        slot_we;
  logic [ghau_pkg::IDX_W-1:0]  slot_waddr;
  ghau_pkg::slot_ent_t         slot_wdata;
  logic [ghau_pkg::IDX_W-1:0]  slot_raddr;
  logic [ghau_pkg::SLOT_W-1:0] slot_rdata;
  logic                        slot_fwd_r, slot_fwd_nxt;
  ghau_pkg::slot_ent_t         slot_fwd_data_r;
  ghau_pkg::slot_ent_t         rd_ent;
  logic                        hit;

  ghau_pkg::stack_op_t    sop;
  ghau_pkg::stack_stat_t  stk;
  ghau_pkg::result_t      res;
  ghau_pkg::result_t      fifo_data;
  logic [ghau_pkg::OCC_W-1:0] fifo_count;
  logic [ghau_pkg::OCC_W:0]   occupancy;
  logic                   accept;

  // The compute stage never stalls, so a transaction may enter as long as the
  // queue can take both the one in flight and this one.
  assign occupancy = (ghau_pkg::OCC_W + 1)'(fifo_count) + (ghau_pkg::OCC_W + 1)'(s1_valid_r);
  assign in_ready  = (occupancy < (ghau_pkg::OCC_W + 1)'(ghau_pkg::OUT_DEPTH));
  assign accept    = in_valid && in_ready;

  // A create looks up the slot that will be on top of the free stack once the
  // transaction now in the compute stage has committed; anything else looks up
  // the presented slot.
  assign slot_raddr = (in_action == ghau_pkg::ACT_CREATE) ? stk.top_nxt : in_slot_index;

  always_comb begin
    rd_ent     = slot_fwd_r ? slot_fwd_data_r : ghau_pkg::slot_ent_t'(slot_rdata);
    hit        = (ghau_pkg::CNT_W'(s1_idx_r) < fresh_r) &&
                 ghau_pkg::gen_match(rd_ent.gen, s1_gen_r);
    sop        = '0;
    sop.slot   = s1_idx_r;
    fresh_nxt  = fresh_r;
    live_nxt   = live_r;
    slot_we    = 1'b0;
    slot_waddr = s1_idx_r;
    slot_wdata = rd_ent;
    res.status = ghau_pkg::ST_STALE;
    res.index  = s1_idx_r;
    res.gen    = s1_gen_r;
    res.active = 1'b0;
    if (s1_valid_r) begin
      unique case (ghau_pkg::action_t'(s1_action_r))
        ghau_pkg::ACT_CREATE: begin
          priority if (stk.depth != '0) begin
            // Reuse the most recently freed slot with its current generation.
            sop.pop           = 1'b1;
            slot_we           = 1'b1;
            slot_waddr        = stk.top;
            slot_wdata.active = 1'b1;
            res.status        = ghau_pkg::ST_OK;
            res.index         = stk.top;
            res.gen           = ghau_pkg::gen_to_port(rd_ent.gen);
            res.active        = 1'b1;
          end else if (fresh_r < ghau_pkg::CNT_W'(ghau_pkg::MAX_SLOTS)) begin
            slot_we           = 1'b1;
            slot_waddr        = ghau_pkg::IDX_W'(fresh_r);
            slot_wdata.gen    = '0;
            slot_wdata.active = 1'b1;
            fresh_nxt         = fresh_r + ghau_pkg::CNT_W'(1);
            res.status        = ghau_pkg::ST_OK;
            res.index         = ghau_pkg::IDX_W'(fresh_r);
            res.gen           = '0;
            res.active        = 1'b1;
          end else begin
            res.status = ghau_pkg::ST_FULL;
            res.index  = '0;
            res.gen    = '0;
          end
          if (res.status == ghau_pkg::ST_OK &&
              live_r < ghau_pkg::CNT_W'(ghau_pkg::MAX_SLOTS)) begin
            live_nxt = live_r + ghau_pkg::CNT_W'(1);
          end
        end
        ghau_pkg::ACT_DESTROY: begin
          if (hit) begin
            slot_we           = 1'b1;
            slot_wdata.gen    = rd_ent.gen + ghau_pkg::GEN_BITS'(1);
            slot_wdata.active = 1'b0;
            sop.push          = (stk.depth < ghau_pkg::CNT_W'(ghau_pkg::MAX_SLOTS));
            if (live_r != '0) begin
              live_nxt = live_r - ghau_pkg::CNT_W'(1);
            end
            res.status = ghau_pkg::ST_OK;
          end
        end
        ghau_pkg::ACT_SET_ACTIVE: begin
          if (hit) begin
            slot_we           = 1'b1;
            slot_wdata.active = s1_actv_r;
            res.status        = ghau_pkg::ST_OK;
            res.active        = s1_actv_r;
          end
        end
        ghau_pkg::ACT_CHECK, ghau_pkg::ACT_QUERY_ACTIVE: begin
          if (hit) begin
            res.status = ghau_pkg::ST_OK;
            res.active = rd_ent.active;
          end
        end
        default: begin
          // Unknown actions answer like a stale handle and change nothing.
        end
      endcase
    end
    res.live     = live_nxt;
    slot_fwd_nxt = slot_we && (slot_waddr == slot_raddr);
  end

  ghau_ram #(
    .WIDTH (ghau_pkg::SLOT_W),
    .DEPTH (ghau_pkg::MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ghau_free_stack u_free_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (sop),
    .stat  (stk)
  );

  ghau_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (res),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (fifo_data),
    .count     (fifo_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fresh_r    <= '0;
      live_r     <= '0;
      slot_fwd_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      fresh_r    <= fresh_nxt;
      live_r     <= live_nxt;
      slot_fwd_r <= slot_fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_idx_r    <= in_slot_index;
      s1_gen_r    <= in_slot_generation;
      s1_actv_r   <= in_active_value;
    end
    slot_fwd_data_r <= slot_wdata;
  end

  assign out_status            = fifo_data.status;
  assign out_handle_index      = fifo_data.index;
  assign out_handle_generation = fifo_data.gen;
  assign out_active_flag       = fifo_data.active;
  assign out_live_count        = fifo_data.live;

  `GHAU_ASSERT_NOW(a_queue_no_overflow, 1'b1,
                   occupancy <= (ghau_pkg::OCC_W + 1)'(ghau_pkg::OUT_DEPTH))
  `GHAU_ASSERT_NEXT(a_fresh_monotonic, 1'b1, fresh_r >= $past(fresh_r))
  `GHAU_ASSERT_NOW(a_created_below_mark, s1_valid_r && res.status == ghau_pkg::ST_OK &&
                   s1_action_r == ghau_pkg::ACT_CREATE,
                   ghau_pkg::CNT_W'(res.index) < fresh_nxt)

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the generational handle allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The limit allows for every transaction meeting the longest sender gap and a
  // sparse receiver, with a wide margin on top.
  localparam int unsigned LIMIT_CYCLES = 200_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MIXED_OPS    = 725;
  localparam int unsigned MAX_PRINTS   = 40;

  // One input transaction as the sender presents it.
  typedef struct packed {
    logic [ghau_pkg::ACT_W-1:0]      action;
    logic [ghau_pkg::IDX_W-1:0]      idx;
    logic [ghau_pkg::GEN_PORT_W-1:0] gen;
    logic                            act;
  } op_item_t;

  // One result transaction as the allocator must return it.
  typedef struct packed {
    ghau_pkg::status_t               status;
    logic [ghau_pkg::IDX_W-1:0]      idx;
    logic [ghau_pkg::GEN_PORT_W-1:0] gen;
    logic                            act;
    logic [ghau_pkg::CNT_W-1:0]      live;
  } answer_t;

  // Receiver behavior; each mode holds for a random number of cycles.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                            in_valid           = 1'b0;
  logic                            in_ready;
  logic [ghau_pkg::ACT_W-1:0]      in_action          = '0;
  logic [ghau_pkg::IDX_W-1:0]      in_slot_index      = '0;
  logic [ghau_pkg::GEN_PORT_W-1:0] in_slot_generation = '0;
  logic                            in_active_value    = 1'b0;

  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      out_status;
  logic [ghau_pkg::IDX_W-1:0]      out_handle_index;
  logic [ghau_pkg::GEN_PORT_W-1:0] out_handle_generation;
  logic                            out_active_flag;
  logic [ghau_pkg::CNT_W-1:0]      out_live_count;

  generational_handle_allocator_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_slot_index         (in_slot_index),
    .in_slot_generation    (in_slot_generation),
    .in_active_value       (in_active_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_handle_index      (out_handle_index),
    .out_handle_generation (out_handle_generation),
    .out_active_flag       (out_active_flag),
    .out_live_count        (out_live_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transactions waiting for the driver, and answers owed by the allocator in order.
  op_item_t op_backlog[$];
  answer_t  owed_answers[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Shadow copy of the allocator state. It advances at every accepted transaction,
  // so it always reflects exactly what the block has been told so far. The stimulus
  // side also peeks at it to build handles that are likely to be valid.
  bit [ghau_pkg::IDX_W-1:0]    free_lifo [ghau_pkg::MAX_SLOTS];
  bit [ghau_pkg::GEN_BITS-1:0] slot_gen  [ghau_pkg::MAX_SLOTS];
  bit                          slot_act  [ghau_pkg::MAX_SLOTS];
  int unsigned                 lifo_depth   = 0;
  int unsigned                 next_fresh   = 0;
  int unsigned                 live_handles = 0;

  // Applies one transaction to the shadow state and returns the answer it must get.
  function automatic answer_t allocator_answer(op_item_t it);
    answer_t                  a;
    logic [ghau_pkg::IDX_W-1:0] s;
    bit                       hit;
    a.status = ghau_pkg::ST_STALE;
    a.idx    = it.idx;
    a.gen    = it.gen;
    a.act    = 1'b0;
    if (it.action == ghau_pkg::ACT_CREATE) begin
      a.idx = '0;
      a.gen = '0;
      if (lifo_depth > 0) begin
        // Recycled slots come back last in, first out, with their current generation.
        lifo_depth--;
        s        = free_lifo[lifo_depth];
        a.status = ghau_pkg::ST_OK;
      end else if (next_fresh < ghau_pkg::MAX_SLOTS) begin
        s           = ghau_pkg::IDX_W'(next_fresh);
        next_fresh++;
        slot_gen[s] = '0;
        a.status    = ghau_pkg::ST_OK;
      end else begin
        a.status = ghau_pkg::ST_FULL;
      end
      if (a.status == ghau_pkg::ST_OK) begin
        slot_act[s] = 1'b1;
        if (live_handles < ghau_pkg::MAX_SLOTS) live_handles++;
        a.idx = s;
        a.gen = ghau_pkg::GEN_PORT_W'(slot_gen[s]);
        a.act = 1'b1;
      end
    end else begin
      // A handle counts only if its slot was ever handed out and the generation
      // matches in every presented bit. Unknown actions never count.
      hit = (it.action <= ghau_pkg::ACT_QUERY_ACTIVE) && (it.idx < next_fresh) &&
            (ghau_pkg::GEN_PORT_W'(slot_gen[it.idx]) == it.gen);
      if (hit) begin
        a.status = ghau_pkg::ST_OK;
        case (it.action)
          ghau_pkg::ACT_DESTROY: begin
            slot_gen[it.idx] = slot_gen[it.idx] + 1'b1;
            slot_act[it.idx] = 1'b0;
            // A slot destroyed again can overfill the stack; the extra push is lost.
            if (lifo_depth < ghau_pkg::MAX_SLOTS) begin
              free_lifo[lifo_depth] = it.idx;
              lifo_depth++;
            end
            if (live_handles > 0) live_handles--;
          end
          ghau_pkg::ACT_SET_ACTIVE: begin
            slot_act[it.idx] = it.act;
          end
          default: begin
          end
        endcase
        a.act = slot_act[it.idx];
      end
    end
    a.live = ghau_pkg::CNT_W'(live_handles);
    return a;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Queues one transaction. The backlog is kept short so that handles picked from
  // the shadow state are rarely out of date by the time they reach the block.
  task automatic push_op(input logic [ghau_pkg::ACT_W-1:0] action, input int unsigned idx,
                         input int unsigned gen, input bit act);
    op_item_t it;
    it.action = action;
    it.idx    = ghau_pkg::IDX_W'(idx);
    it.gen    = ghau_pkg::GEN_PORT_W'(gen);
    it.act    = act;
    while (op_backlog.size() >= 2) @(negedge clk);
    op_backlog = {op_backlog, it};
  endtask

  // One random transaction. Most handle operations carry a handle taken from the
  // shadow state; some carry the generation one past it, which hits a slot that
  // has just been destroyed, and the rest carry random fields.
  task automatic queue_mixed_op();
    int unsigned                     roll;
    logic [ghau_pkg::ACT_W-1:0]      action;
    logic [ghau_pkg::IDX_W-1:0]      idx;
    logic [ghau_pkg::GEN_PORT_W-1:0] gen;
    roll = $urandom_range(0, 99);
    idx  = ghau_pkg::IDX_W'($urandom);
    gen  = ghau_pkg::GEN_PORT_W'($urandom);
    if (roll < 30)      action = ghau_pkg::ACT_CREATE;
    else if (roll < 50) action = ghau_pkg::ACT_DESTROY;
    else if (roll < 62) action = ghau_pkg::ACT_CHECK;
    else if (roll < 76) action = ghau_pkg::ACT_SET_ACTIVE;
    else if (roll < 90) action = ghau_pkg::ACT_QUERY_ACTIVE;
    else action = ghau_pkg::ACT_W'($urandom_range(ghau_pkg::ACT_QUERY_ACTIVE + 1,
                                                  (1 << ghau_pkg::ACT_W) - 1));
    if (action != ghau_pkg::ACT_CREATE && next_fresh > 0 && $urandom_range(0, 9) < 8) begin
      idx = ghau_pkg::IDX_W'($urandom_range(0, next_fresh - 1));
      gen = ghau_pkg::GEN_PORT_W'(slot_gen[idx]) +
            ghau_pkg::GEN_PORT_W'($urandom_range(0, 7) == 0);
    end
    push_op(action, idx, gen, $urandom_range(0, 1));
  endtask

  // Stimulus: a directed opening, then mixed random traffic.
  initial begin : stimulus
    int unsigned k;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. From reset, creates hand out slots 0, 1 and 2 with
    // generation 0, so the handles below are known ahead of time.
    push_op(ghau_pkg::ACT_CHECK, 0, 0, 1'b0);                  // nothing handed out yet
    push_op(ghau_pkg::ACT_CREATE, $urandom, $urandom, 1'b1);   // create ignores the fields
    push_op(ghau_pkg::ACT_CREATE, ghau_pkg::MAX_SLOTS - 1,
            (1 << ghau_pkg::GEN_PORT_W) - 1, 1'b0);
    push_op(ghau_pkg::ACT_CREATE, 0, 0, 1'b1);
    push_op(ghau_pkg::ACT_CHECK, 0, 0, 1'b0);
    push_op(ghau_pkg::ACT_CHECK, 0, (1 << ghau_pkg::GEN_PORT_W) - 1, 1'b1); // wrong generation
    push_op(ghau_pkg::ACT_QUERY_ACTIVE, ghau_pkg::MAX_SLOTS - 1, 0, 1'b1); // never handed out
    push_op(ghau_pkg::ACT_SET_ACTIVE, 1, 0, 1'b0);
    push_op(ghau_pkg::ACT_QUERY_ACTIVE, 1, 0, 1'b0);
    push_op(ghau_pkg::ACT_SET_ACTIVE, 1, 0, 1'b1);
    push_op(ghau_pkg::ACT_DESTROY, 1, 0, 1'b1);
    push_op(ghau_pkg::ACT_QUERY_ACTIVE, 1, 0, 1'b0);           // stale after the destroy
    push_op(ghau_pkg::ACT_DESTROY, 1, 1, 1'b0);                // destroy the free slot again
    push_op(ghau_pkg::ACT_DESTROY, 2, 0, 1'b0);
    push_op(ghau_pkg::ACT_DESTROY, 2, 1, 1'b1);                // live count must stay at zero
    for (k = ghau_pkg::ACT_QUERY_ACTIVE + 1; k < (1 << ghau_pkg::ACT_W); k++)
      push_op(ghau_pkg::ACT_W'(k), 0, 0, 1'b1);                // unknown actions
    push_op(ghau_pkg::ACT_SET_ACTIVE, 0, 1, 1'b1);             // stale handle leaves the flag
    repeat (4) push_op(ghau_pkg::ACT_CREATE, $urandom, $urandom, $urandom_range(0, 1));
    push_op(ghau_pkg::ACT_CREATE, 0, 0, 1'b0);                 // stack empty again, fresh slot
    push_op(ghau_pkg::ACT_DESTROY, 3, (1 << ghau_pkg::GEN_PORT_W) - 1, 1'b1);

    repeat (MIXED_OPS) queue_mixed_op();

    // Wait for the last transaction to be taken and every answer to come back,
    // then give the block a little time to show any extra result.
    while (op_backlog.size() != 0 || in_valid) @(negedge clk);
    while (owed_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Driver. It sends in bursts of random length separated by random gaps, with an
  // occasional long burst and no gap at all. Valid and payload hold until taken.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : driver
    op_item_t nxt;
    if (!rst_n) begin
      in_valid           <= 1'b0;
      in_action          <= '0;
      in_slot_index      <= '0;
      in_slot_generation <= '0;
      in_active_value    <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        nxt = op_backlog.pop_front();
        in_valid           <= 1'b1;
        in_action          <= nxt.action;
        in_slot_index      <= nxt.idx;
        in_slot_generation <= nxt.gen;
        in_active_value    <= nxt.act;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(0, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. It switches between always ready, a coin flip, mostly stalled and a
  // fixed comb, so stalls land on every stage of the result queue.
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_phase     = 0;

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_COMB));
        rx_mode_left = $urandom_range(20, 300);
      end else begin
        rx_mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_phase % 3) != 0;
      endcase
    end
  end

  // Monitor. Every accepted input transaction is run through the shadow model, and
  // every accepted result transaction is checked against the oldest owed answer.
  always @(posedge clk) begin : monitor
    op_item_t got;
    answer_t  due;
    answer_t  want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        got = '{in_action, in_slot_index, in_slot_generation, in_active_value};
        due = allocator_answer(got);
        owed_answers = {owed_answers, due};
      end
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          flag_mismatch("result transaction with nothing outstanding");
        end else begin
          want = owed_answers.pop_front();
          if (out_status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_handle_index !== want.idx)
            flag_mismatch($sformatf("index %0d, want %0d", out_handle_index, want.idx));
          if (out_handle_generation !== want.gen)
            flag_mismatch($sformatf("generation %0d, want %0d",
                                    out_handle_generation, want.gen));
          if (out_active_flag !== want.act)
            flag_mismatch($sformatf("active %0d, want %0d", out_active_flag, want.act));
          if (out_live_count !== want.live)
            flag_mismatch($sformatf("live %0d, want %0d", out_live_count, want.live));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
